@@ design/gie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_pkg
// shared constants, codes and types of the watched-input event reporter
// ----------------------------------------------------------------------------
package gie_pkg;

    localparam int SLOTS       = 8;
    localparam int PINS        = 32;
    localparam int MAX_REPORTS = 8;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int RPT_W    = $clog2(MAX_REPORTS + 1);

    localparam int CMD_W    = 2;
    localparam int PIN_W    = 5;
    localparam int SECS_W   = 16;
    localparam int TIME_W   = 32;
    localparam int LEVELS_W = 32;
    localparam int PERIOD_W = 26;

    localparam logic [PERIOD_W-1:0] MS_PER_SECOND = PERIOD_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_REL,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [PIN_W-1:0]    pin;
        logic [PERIOD_W-1:0] period_ms;
    } t_meta;

    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic              last_level;
    } t_hist;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              meta_we;
        logic [SLOT_W-1:0] meta_addr;
        t_meta             meta_wdata;
        logic              hist_we;
        logic [SLOT_W-1:0] hist_addr;
        t_hist             hist_wdata;
    } t_mem_req;

    typedef struct packed {
        t_meta meta;
        t_hist hist;
    } t_mem_rsp;

endpackage

@@ design/gie_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_in_if
// command channel: tick, add and release words
// ----------------------------------------------------------------------------
interface gie_in_if;
    logic                          valid;
    logic                          ready;
    logic [gie_pkg::CMD_W-1:0]     cmd;
    logic [gie_pkg::PIN_W-1:0]     pin_id;
    logic [gie_pkg::SECS_W-1:0]    period_seconds;
    logic [gie_pkg::TIME_W-1:0]    now_ms;
    logic [gie_pkg::LEVELS_W-1:0]  pin_levels;

    modport source (
        output valid, cmd, pin_id, period_seconds, now_ms, pin_levels,
        input  ready
    );
    modport sink (
        input  valid, cmd, pin_id, period_seconds, now_ms, pin_levels,
        output ready
    );
endinterface

@@ design/gie_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_out_if
// report channel: one word per reported pin level
// ----------------------------------------------------------------------------
interface gie_out_if;
    logic                      valid;
    logic                      ready;
    logic [gie_pkg::PIN_W-1:0] report_pin;
    logic                      report_level;
    logic                      last_report;

    modport source (
        output valid, report_pin, report_level, last_report,
        input  ready
    );
    modport sink (
        input  valid, report_pin, report_level, last_report,
        output ready
    );
endinterface

@@ design/gpio_input_event_reporter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_input_event_reporter
// watched-pin table with periodic and on-change level reports
// ----------------------------------------------------------------------------
// usage
//   i_in carries command words: tick (time and all pin levels), add
//   (pin and period in seconds) or release (pin); o_out carries report
//   words (pin, level, last-of-tick flag)
//   a word is taken when valid and ready are both high
// command handling
//   an add is done at the edge taking it; a release lasts as long as the
//   one-entry-per-cycle search of the pin memory and the return to idle
//   a tick scans every slot through the slot memory, one slot per cycle
//   while the scan is not stalled, then hands over the final report; a
//   report is held until the next due slot is found or the scan ends
//   and then moves to o_out, the final one marked last_report
//   one command word is in flight at a time
// reset
//   all slots free; stored pins, periods, times and levels read as zero
// stall
//   one report waits in the output register and one more is held inside;
//   the scan pauses when a third is found while o_out stays stalled, and
//   new commands are taken again once the scan is through
module gpio_input_event_reporter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gie_in_if.sink    i_in,
    gie_out_if.source o_out
);

    // memory request and read data between sequencer and slot table
    gie_pkg::t_mem_req w_mem_req;
    gie_pkg::t_mem_rsp w_mem_rsp;

    // sequencer: owns the enable bits, the scan and the report registers
    gie_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_req (w_mem_req),
        .i_mem_rsp (w_mem_rsp)
    );

    // slot table: pin/period and last time/level per slot
    gie_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rsp   (w_mem_rsp)
    );

    // timer/level write-back only happens inside a tick scan, never while
    // a new command can be taken
    a_hist_only_in_scan: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.hist_we |-> !i_in.ready
    ) else $error("slot history written while accepting commands");

    // an add never overlaps a scan write-back
    a_single_writer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_req.meta_we && w_mem_req.hist_we)
    ) else $error("pin table and history written in the same cycle");

    // the scan reads ahead one slot, so it never reads the slot it writes
    a_no_rw_overlap: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_req.rd_en && w_mem_req.hist_we)
            |-> (w_mem_req.rd_addr != w_mem_req.hist_addr)
    ) else $error("read and write-back hit the same slot");

    // pin table only changes while idle
    a_meta_only_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.meta_we |-> (i_in.ready && i_in.valid)
    ) else $error("pin table written outside an accepted add");

endmodule

@@ design/gie_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_slot_mem
// slot table: pin/period memory and time/level memory, registered read
// ----------------------------------------------------------------------------
module gie_slot_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gie_pkg::t_mem_req i_req,
    output gie_pkg::t_mem_rsp o_rsp
);

    gie_pkg::t_meta r_meta_mem [gie_pkg::SLOTS];
    gie_pkg::t_hist r_hist_mem [gie_pkg::SLOTS];

    // entries never written read as zero
    logic [gie_pkg::SLOTS-1:0] r_meta_ok;
    logic [gie_pkg::SLOTS-1:0] r_hist_ok;

    gie_pkg::t_meta r_meta_q;
    gie_pkg::t_hist r_hist_q;
    logic           r_meta_ok_q;
    logic           r_hist_ok_q;

    always_ff @(posedge i_clk) begin
        if (i_req.meta_we) begin
            r_meta_mem[i_req.meta_addr] <= i_req.meta_wdata;
        end
        if (i_req.hist_we) begin
            r_hist_mem[i_req.hist_addr] <= i_req.hist_wdata;
        end
        if (i_req.rd_en) begin
            r_meta_q <= r_meta_mem[i_req.rd_addr];
            r_hist_q <= r_hist_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_ok   <= '0;
            r_hist_ok   <= '0;
            r_meta_ok_q <= 1'b0;
            r_hist_ok_q <= 1'b0;
        end else begin
            if (i_req.meta_we) begin
                r_meta_ok[i_req.meta_addr] <= 1'b1;
            end
            if (i_req.hist_we) begin
                r_hist_ok[i_req.hist_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_meta_ok_q <= r_meta_ok[i_req.rd_addr];
                r_hist_ok_q <= r_hist_ok[i_req.rd_addr];
            end
        end
    end

    assign o_rsp.meta = r_meta_ok_q ? r_meta_q : '0;
    assign o_rsp.hist = r_hist_ok_q ? r_hist_q : '0;

endmodule

@@ design/gie_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_seq
// command sequencer: slot allocation, release search and tick scan
// ----------------------------------------------------------------------------
module gie_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gie_in_if.sink            i_in,
    gie_out_if.source         o_out,
    output gie_pkg::t_mem_req o_mem_req,
    input  gie_pkg::t_mem_rsp i_mem_rsp
);

    gie_pkg::t_state r_state, n_state;

    logic [gie_pkg::SLOTS-1:0]    r_enabled, n_enabled;
    logic [gie_pkg::CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                         r_ev_valid, n_ev_valid;
    logic [gie_pkg::SLOT_W-1:0]   r_ev_idx, n_ev_idx;
    logic [gie_pkg::RPT_W-1:0]    r_count, n_count;
    logic [gie_pkg::TIME_W-1:0]   r_now, n_now;
    logic [gie_pkg::LEVELS_W-1:0] r_levels, n_levels;
    logic [gie_pkg::PIN_W-1:0]    r_rel_pin, n_rel_pin;

    // held report: its last flag is known only when the next one shows up or the scan ends
    logic                         r_pend_valid, n_pend_valid;
    logic [gie_pkg::PIN_W-1:0]    r_pend_pin, n_pend_pin;
    logic                         r_pend_level, n_pend_level;

    logic                         r_out_valid, n_out_valid;
    logic [gie_pkg::PIN_W-1:0]    r_out_pin, n_out_pin;
    logic                         r_out_level, n_out_level;
    logic                         r_out_last, n_out_last;

    gie_pkg::t_mem_req            w_req;
    gie_pkg::t_meta               w_meta;
    gie_pkg::t_hist               w_hist;
    logic                         w_level;
    logic [gie_pkg::TIME_W-1:0]   w_diff;
    logic                         w_due;
    logic                         w_fire;
    logic                         w_out_free;
    logic                         w_stall;
    logic                         w_free_any;
    logic [gie_pkg::SLOT_W-1:0]   w_free_idx;
    logic                         w_scan_end;

    assign w_meta  = i_mem_rsp.meta;
    assign w_hist  = i_mem_rsp.hist;
    assign w_level = r_levels[w_meta.pin];
    assign w_diff  = r_now - w_hist.last_time;

    // periodic slot: positive elapsed time beyond the period; else level change
    assign w_due = (w_meta.period_ms != '0)
                 ? (!w_diff[gie_pkg::TIME_W-1]
                    && (w_diff > gie_pkg::TIME_W'(w_meta.period_ms)))
                 : (w_level != w_hist.last_level);

    assign w_fire = r_ev_valid && r_enabled[r_ev_idx]
                 && (r_count < gie_pkg::RPT_W'(gie_pkg::MAX_REPORTS)) && w_due;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_stall    = w_fire && r_pend_valid && !w_out_free;
    assign w_scan_end = !r_ev_valid && (r_rd_idx == gie_pkg::CNT_W'(gie_pkg::SLOTS));

    // lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = gie_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_enabled[i]) begin
                w_free_any = 1'b1;
                w_free_idx = gie_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_enabled    = r_enabled;
        n_rd_idx     = r_rd_idx;
        n_ev_valid   = r_ev_valid;
        n_ev_idx     = r_ev_idx;
        n_count      = r_count;
        n_now        = r_now;
        n_levels     = r_levels;
        n_rel_pin    = r_rel_pin;
        n_pend_valid = r_pend_valid;
        n_pend_pin   = r_pend_pin;
        n_pend_level = r_pend_level;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pin    = r_out_pin;
        n_out_level  = r_out_level;
        n_out_last   = r_out_last;
        w_req        = '0;

        unique case (r_state)
            gie_pkg::ST_IDLE: begin
                n_ev_valid = 1'b0;
                if (i_in.valid) begin
                    case (i_in.cmd)
                        gie_pkg::CMD_TICK: begin
                            n_now        = i_in.now_ms;
                            n_levels     = i_in.pin_levels;
                            n_rd_idx     = '0;
                            n_count      = '0;
                            n_pend_valid = 1'b0;
                            n_state      = gie_pkg::ST_TICK;
                        end
                        gie_pkg::CMD_ADD: begin
                            if (w_free_any && (32'(i_in.pin_id) < gie_pkg::PINS)) begin
                                n_enabled[w_free_idx]  = 1'b1;
                                w_req.meta_we          = 1'b1;
                                w_req.meta_addr        = w_free_idx;
                                w_req.meta_wdata.pin   = i_in.pin_id;
                                w_req.meta_wdata.period_ms =
                                    gie_pkg::PERIOD_W'(i_in.period_seconds)
                                    * gie_pkg::MS_PER_SECOND;
                            end
                        end
                        gie_pkg::CMD_RELEASE: begin
                            n_rel_pin = i_in.pin_id;
                            n_rd_idx  = '0;
                            n_state   = gie_pkg::ST_REL;
                        end
                        default: ;
                    endcase
                end
            end

            gie_pkg::ST_TICK: begin
                if (!w_stall) begin
                    if (r_rd_idx < gie_pkg::CNT_W'(gie_pkg::SLOTS)) begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = r_rd_idx[gie_pkg::SLOT_W-1:0];
                        n_rd_idx      = r_rd_idx + 1'b1;
                        n_ev_valid    = 1'b1;
                        n_ev_idx      = r_rd_idx[gie_pkg::SLOT_W-1:0];
                    end else begin
                        n_ev_valid = 1'b0;
                    end
                    if (w_fire) begin
                        w_req.hist_we              = 1'b1;
                        w_req.hist_addr            = r_ev_idx;
                        w_req.hist_wdata.last_time = r_now;
                        w_req.hist_wdata.last_level =
                            (w_meta.period_ms != '0) ? w_hist.last_level : w_level;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_pin   = r_pend_pin;
                            n_out_level = r_pend_level;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_pin   = w_meta.pin;
                        n_pend_level = w_level;
                        n_count      = r_count + 1'b1;
                    end
                    if (w_scan_end) begin
                        n_state = r_pend_valid ? gie_pkg::ST_FLUSH : gie_pkg::ST_IDLE;
                    end
                end
            end

            gie_pkg::ST_REL: begin
                if (r_ev_valid && (w_meta.pin == r_rel_pin)) begin
                    n_enabled[r_ev_idx] = 1'b0;
                    n_ev_valid          = 1'b0;
                    n_state             = gie_pkg::ST_IDLE;
                end else begin
                    if (r_rd_idx < gie_pkg::CNT_W'(gie_pkg::SLOTS)) begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = r_rd_idx[gie_pkg::SLOT_W-1:0];
                        n_rd_idx      = r_rd_idx + 1'b1;
                        n_ev_valid    = 1'b1;
                        n_ev_idx      = r_rd_idx[gie_pkg::SLOT_W-1:0];
                    end else begin
                        n_ev_valid = 1'b0;
                    end
                    if (w_scan_end) begin
                        n_state = gie_pkg::ST_IDLE;
                    end
                end
            end

            gie_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pin    = r_pend_pin;
                    n_out_level  = r_pend_level;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = gie_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gie_pkg::ST_IDLE;
            r_enabled    <= '0;
            r_rd_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_enabled    <= n_enabled;
            r_rd_idx     <= n_rd_idx;
            r_ev_valid   <= n_ev_valid;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx     <= n_ev_idx;
        r_now        <= n_now;
        r_levels     <= n_levels;
        r_rel_pin    <= n_rel_pin;
        r_pend_pin   <= n_pend_pin;
        r_pend_level <= n_pend_level;
        r_out_pin    <= n_out_pin;
        r_out_level  <= n_out_level;
        r_out_last   <= n_out_last;
    end

    assign i_in.ready         = (r_state == gie_pkg::ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.report_pin   = r_out_pin;
    assign o_out.report_level = r_out_level;
    assign o_out.last_report  = r_out_last;
    assign o_mem_req          = w_req;

endmodule

@@ test/gie_report_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gie_report_checker
// watches the command and report channels of the event reporter, keeps its
// own slot table, predicts the report words of every tick and compares them
// in order with the words that leave the block
// ----------------------------------------------------------------------------
module gie_report_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    gie_in_if    i_cmd_mon,
    gie_out_if   i_rpt_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import gie_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             level;
        logic             last;
    } t_report;

    // slot table as the block should hold it
    logic                slot_used   [SLOTS];
    logic [PIN_W-1:0]    slot_pin    [SLOTS];
    logic [PERIOD_W-1:0] slot_period [SLOTS];
    logic [TIME_W-1:0]   slot_stamp  [SLOTS];
    logic                slot_level  [SLOTS];

    t_report report_queue[$];

    task automatic flag_mismatch(input string what);
        if (o_fail_count < MAX_PRINTED)
            $display("[%0t] report mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic watch_pin(input logic [PIN_W-1:0] pin, input logic [SECS_W-1:0] secs);
        if (int'(pin) >= PINS)
            return;
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_used[s]) begin
                slot_used[s]   = 1'b1;
                slot_pin[s]    = pin;
                slot_period[s] = PERIOD_W'(PERIOD_W'(secs) * MS_PER_SECOND);
                return;
            end
        end
    endtask

    // first slot whose stored pin matches, used or not
    task automatic unwatch_pin(input logic [PIN_W-1:0] pin);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_pin[s] == pin) begin
                slot_used[s] = 1'b0;
                return;
            end
        end
    endtask

    task automatic scan_slots(input logic [TIME_W-1:0] now, input logic [LEVELS_W-1:0] levels);
        t_report           found [MAX_REPORTS];
        int                n;
        logic              level;
        logic              due;
        logic [TIME_W-1:0] elapsed;
        n = 0;
        for (int s = 0; s < SLOTS && n < MAX_REPORTS; s++) begin
            if (slot_used[s]) begin
                level = levels[slot_pin[s]];
                due   = 1'b0;
                if (slot_period[s] != '0) begin
                    // signed wrapping difference, negative never fires
                    elapsed = now - slot_stamp[s];
                    due = !elapsed[TIME_W-1] && (elapsed > TIME_W'(slot_period[s]));
                end else if (level != slot_level[s]) begin
                    slot_level[s] = level;
                    due = 1'b1;
                end
                if (due) begin
                    slot_stamp[s] = now;
                    found[n] = '{slot_pin[s], level, 1'b0};
                    n++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            report_queue.push_back(found[k]);
        end
    endtask

    task automatic check_report();
        t_report want;
        if (report_queue.size() == 0) begin
            flag_mismatch($sformatf("unexpected word pin %0d level %0d last %0d",
                i_rpt_mon.report_pin, i_rpt_mon.report_level, i_rpt_mon.last_report));
            return;
        end
        want = report_queue.pop_front();
        if (i_rpt_mon.report_pin !== want.pin)
            flag_mismatch($sformatf("report_pin %0d, want %0d",
                i_rpt_mon.report_pin, want.pin));
        if (i_rpt_mon.report_level !== want.level)
            flag_mismatch($sformatf("report_level %0d on pin %0d, want %0d",
                i_rpt_mon.report_level, want.pin, want.level));
        if (i_rpt_mon.last_report !== want.last)
            flag_mismatch($sformatf("last_report %0d on pin %0d, want %0d",
                i_rpt_mon.last_report, want.pin, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_used[s]   = 1'b0;
                slot_pin[s]    = '0;
                slot_period[s] = '0;
                slot_stamp[s]  = '0;
                slot_level[s]  = 1'b0;
            end
            report_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_rpt_mon.valid && i_rpt_mon.ready)
                check_report();
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                case (i_cmd_mon.cmd)
                    CMD_TICK:    scan_slots(i_cmd_mon.now_ms, i_cmd_mon.pin_levels);
                    CMD_ADD:     watch_pin(i_cmd_mon.pin_id, i_cmd_mon.period_seconds);
                    CMD_RELEASE: unwatch_pin(i_cmd_mon.pin_id);
                    default:     ;
                endcase
            end
        end
        o_pending = report_queue.size();
    end

endmodule

@@ test/tb_gpio_input_event_reporter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gpio_input_event_reporter
// drives tick, add and release words into the event reporter in random
// bursts while the report side stalls on its own pattern; a checker beside
// the block predicts every report word and counts mismatches
// ----------------------------------------------------------------------------
module tb_gpio_input_event_reporter;

    // encoding the block has no use for, it must be swallowed silently
    localparam logic [gie_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // longest run of cycles with no word moving on either side
    localparam int IDLE_LIMIT   = 5000;
    // a full scan plus the handover of its last report, with margin
    localparam int DRAIN_CYCLES = 2 * gie_pkg::SLOTS + 8;
    localparam int RANDOM_WORDS = 215;

    logic i_clk;
    logic i_rst_n;

    gie_in_if  cmd_bus ();
    gie_out_if rpt_bus ();

    int fail_count;
    int reports_pending;
    int idle_cycles;
    int burst_left;
    int random_count;

    logic [gie_pkg::TIME_W-1:0]   wall_ms;
    logic [gie_pkg::LEVELS_W-1:0] pin_state;

    gpio_input_event_reporter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (rpt_bus)
    );

    gie_report_checker u_report_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_bus),
        .i_rpt_mon    (rpt_bus),
        .o_fail_count (fail_count),
        .o_pending    (reports_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // present one word at the falling edge and hold it until it is taken;
    // valid stays high into the next word unless a gap is inserted
    task automatic send_word(input logic [gie_pkg::CMD_W-1:0] cmd,
                             input logic [gie_pkg::PIN_W-1:0] pin,
                             input logic [gie_pkg::SECS_W-1:0] secs,
                             input logic [gie_pkg::TIME_W-1:0] now,
                             input logic [gie_pkg::LEVELS_W-1:0] levels);
        @(negedge i_clk);
        cmd_bus.valid          = 1'b1;
        cmd_bus.cmd            = cmd;
        cmd_bus.pin_id         = pin;
        cmd_bus.period_seconds = secs;
        cmd_bus.now_ms         = now;
        cmd_bus.pin_levels     = levels;
        @(posedge i_clk);
        while (!cmd_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // bursts of random length, usually separated by a random gap
    task automatic issue_word(input logic [gie_pkg::CMD_W-1:0] cmd,
                              input logic [gie_pkg::PIN_W-1:0] pin,
                              input logic [gie_pkg::SECS_W-1:0] secs,
                              input logic [gie_pkg::TIME_W-1:0] now,
                              input logic [gie_pkg::LEVELS_W-1:0] levels);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 20));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_word(cmd, pin, secs, now, levels);
    endtask

    // hold the sender until every predicted report is out and the scan is over
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        while (reports_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // mostly pins from a small pool so releases find their slot
    function automatic logic [gie_pkg::PIN_W-1:0] pick_pin();
        if ($urandom_range(0, 3) != 0)
            return gie_pkg::PIN_W'($urandom_range(0, 7));
        return gie_pkg::PIN_W'($urandom_range(0, gie_pkg::PINS - 1));
    endfunction

    function automatic logic [gie_pkg::SECS_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return gie_pkg::SECS_W'($urandom_range(0, 2));
        if (r < 85)
            return gie_pkg::SECS_W'($urandom_range(0, 65535));
        return '1;
    endfunction

    task automatic random_word();
        int                         r;
        logic [gie_pkg::TIME_W-1:0] step;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // time mostly moves forward a little, sometimes back or anywhere
            step = $urandom_range(0, 99);
            if (step < 80)
                wall_ms = wall_ms + $urandom_range(0, 2500);
            else if (step < 90)
                wall_ms = wall_ms - $urandom_range(0, 3000);
            else
                wall_ms = $urandom;
            // a few pins toggle at a time, now and then all of them at random
            if ($urandom_range(0, 9) < 7)
                pin_state = pin_state ^ ($urandom & $urandom & $urandom);
            else
                pin_state = $urandom;
            issue_word(gie_pkg::CMD_TICK, gie_pkg::PIN_W'($urandom),
                       gie_pkg::SECS_W'($urandom), wall_ms, pin_state);
        end else if (r < 80) begin
            issue_word(gie_pkg::CMD_ADD, pick_pin(), pick_period(), $urandom, $urandom);
        end else if (r < 95) begin
            issue_word(gie_pkg::CMD_RELEASE, pick_pin(), gie_pkg::SECS_W'($urandom),
                       $urandom, $urandom);
        end else begin
            issue_word(CMD_UNUSED, gie_pkg::PIN_W'($urandom), gie_pkg::SECS_W'($urandom),
                       $urandom, $urandom);
        end
        if (r < 95)
            random_count++;
    endtask

    // ------------------------------------------------------------------
    // receiver side: full speed, coin-flip stalls, or a fixed stall rhythm
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        int rhythm;
        rpt_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode   = $urandom_range(0, 2);
            span   = $urandom_range(10, 60);
            rhythm = $urandom_range(2, 8);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    0:       rpt_bus.ready = 1'b1;
                    1:       rpt_bus.ready = 1'($urandom_range(0, 1));
                    default: rpt_bus.ready = (c % rhythm) == 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: nothing moving on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rpt_bus.valid && rpt_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL gpio_input_event_reporter");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        idle_cycles            = 0;
        burst_left             = 0;
        random_count           = 0;
        wall_ms                = '0;
        pin_state              = '0;
        i_rst_n                = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.cmd            = gie_pkg::CMD_TICK;
        cmd_bus.pin_id         = '0;
        cmd_bus.period_seconds = '0;
        cmd_bus.now_ms         = '0;
        cmd_bus.pin_levels     = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: a tick reports nothing, a release of pin zero hits
        // the free slot zero, the unused code does nothing
        issue_word(gie_pkg::CMD_TICK, '0, '0, '0, '1);
        issue_word(gie_pkg::CMD_RELEASE, '0, '0, '0, '0);
        issue_word(CMD_UNUSED, '1, '1, '1, '1);

        // fill all eight slots: on-change and periodic, both pin extremes,
        // the largest period, the same pin watched twice
        issue_word(gie_pkg::CMD_ADD, 5'd0,  16'd0,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd31, 16'hFFFF, '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd5,  16'd1,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd5,  16'd0,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd10, 16'd2,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd11, 16'd0,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd12, 16'd0,    '0, '0);
        issue_word(gie_pkg::CMD_ADD, 5'd13, 16'd3,    '0, '0);
        // table full, this add is dropped
        issue_word(gie_pkg::CMD_ADD, 5'd20, 16'd0,    '0, '0);

        // all levels high: only the on-change slots report
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'd0, '1);
        // one second and a bit: the one-second slot fires, levels fall
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'd1001, '0);
        // half the range away: sign bit set for slots never fired
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'h8000_0000, '1);
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        // time jumps backwards for the one-second slot, forward for others
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'h7FFF_FFFF, 32'h5555_5555);

        // release frees the first match, a pin with no slot changes nothing
        issue_word(gie_pkg::CMD_RELEASE, 5'd5,  '0, '0, '0);
        issue_word(gie_pkg::CMD_RELEASE, 5'd17, '0, '0, '0);
        // the freed slot is claimed again and keeps its old level and time
        issue_word(gie_pkg::CMD_ADD, 5'd7, 16'd0, '0, '0);
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'h8000_1000, 32'h0000_0080);
        issue_word(gie_pkg::CMD_RELEASE, 5'd31, '0, '0, '0);
        issue_word(gie_pkg::CMD_TICK, '0, '0, 32'h8000_2000, 32'hFFFF_FF7F);

        // let the table settle before the random part
        wall_ms   = 32'h8000_2000;
        pin_state = 32'hFFFF_FF7F;
        wait_drained();

        while (random_count < RANDOM_WORDS) begin
            random_word();
            // one more full stop halfway through
            if (random_count == RANDOM_WORDS / 2)
                wait_drained();
        end

        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        while (reports_pending != 0)
            @(negedge i_clk);
        // anything arriving now is a word nobody predicted
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && reports_pending == 0)
            $display("PASS gpio_input_event_reporter");
        else
            $display("FAIL gpio_input_event_reporter");
        $finish;
    end

endmodule

@@ filelist.f @@
design/gie_pkg.sv
design/gie_in_if.sv
design/gie_out_if.sv
design/gie_slot_mem.sv
design/gie_seq.sv
design/gpio_input_event_reporter.sv
test/gie_report_checker.sv
test/tb_gpio_input_event_reporter.sv
